>>> hw/rtl/apx4_pkg.sv
// ----------------------------------------------------------------------------
// apx4_pkg: shared types and constants for the four-band allpass crossover
// Holds the register indexes, scratch slot map, micro-op format and the
// micro-program that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package apx4_pkg;

    // Sample and coefficient formats
    localparam int SAMPLE_W   = 24;
    localparam int SAMPLE_MAX = 8388607;
    localparam int SAMPLE_MIN = -8388608;
    localparam int COEF_W     = 24;
    localparam int CFG_W      = 48;
    localparam int MAX_CH     = 2;

    // Multiplier operand and product widths (coefficient times 25-bit slice)
    localparam int SLICE_W = 25;
    localparam int MUL_W   = COEF_W + SLICE_W;
    localparam int EXT_W   = 49;
    // Full product width: a 24-bit coefficient times a value of up to 49 bits
    localparam int FULL_W  = COEF_W + SLICE_W + 24;

    // Stream widths
    localparam int IN_DATA_W  = 2 * SAMPLE_W;
    localparam int BAND_COUNT = 4;
    localparam int OUT_DATA_W = BAND_COUNT * MAX_CH * SAMPLE_W;

    // Configuration register indexes
    localparam int REG_COUNT = 6;
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_MID2  = 3'd0;
    localparam reg_idx_t REG_MID1  = 3'd1;
    localparam reg_idx_t REG_LOW2  = 3'd2;
    localparam reg_idx_t REG_LOW1  = 3'd3;
    localparam reg_idx_t REG_HIGH2 = 3'd4;
    localparam reg_idx_t REG_HIGH1 = 3'd5;

    // Scratch slots, one set per channel. State words come first.
    typedef logic [4:0] slot_t;
    localparam int    SLOT_COUNT = 22;
    localparam slot_t SLOT_MS1  = 5'd0;
    localparam slot_t SLOT_MS2  = 5'd1;
    localparam slot_t SLOT_MS   = 5'd2;
    localparam slot_t SLOT_CS1  = 5'd3;
    localparam slot_t SLOT_CS2  = 5'd4;
    localparam slot_t SLOT_LS1  = 5'd5;
    localparam slot_t SLOT_LS2  = 5'd6;
    localparam slot_t SLOT_LS   = 5'd7;
    localparam slot_t SLOT_HS1  = 5'd8;
    localparam slot_t SLOT_HS2  = 5'd9;
    localparam slot_t SLOT_HS   = 5'd10;
    localparam slot_t SLOT_IN   = 5'd11;  // input sample, never stored
    localparam slot_t SLOT_XS   = 5'd12;
    localparam slot_t SLOT_Y    = 5'd13;
    localparam slot_t SLOT_T    = 5'd14;
    localparam slot_t SLOT_F    = 5'd15;
    localparam slot_t SLOT_Y1   = 5'd16;
    localparam slot_t SLOT_LO   = 5'd17;
    localparam slot_t SLOT_HI   = 5'd18;
    localparam slot_t SLOT_CY   = 5'd19;
    localparam slot_t SLOT_OUT  = 5'd20;
    localparam slot_t SLOT_ZERO = 5'd21;  // never written, always reads zero

    // Output bands
    typedef logic [1:0] band_t;
    localparam band_t BAND_LL = 2'd0;
    localparam band_t BAND_LH = 2'd1;
    localparam band_t BAND_HL = 2'd2;
    localparam band_t BAND_HH = 2'd3;

    // Micro-op flag values
    localparam logic K_LO    = 1'b0;
    localparam logic K_HI    = 1'b1;
    localparam logic NO_MUL  = 1'b0;
    localparam logic USE_MUL = 1'b1;
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_SUB  = 1'b1;
    localparam logic NO_OUT  = 1'b0;
    localparam logic TO_OUT  = 1'b1;

    // Micro-program layout
    localparam int STEP_W    = 6;
    localparam int STEP_COMP = 10;
    localparam int STEP_LOW  = 14;
    localparam int STEP_HIGH = 24;
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd33;

    // One micro-op: dst = sat(b +/- (use_mul ? coef*a : a))
    typedef struct packed {
        slot_t    a_slot;
        slot_t    b_slot;
        slot_t    dst_slot;
        reg_idx_t cfg_sel;
        logic     coef_hi;
        logic     use_mul;
        logic     sub;
        logic     out_en;
        band_t    out_band;
    } uop_t;

    function automatic uop_t mk(slot_t a, slot_t b, slot_t d, reg_idx_t r, logic hi,
                                logic mul, logic sub, logic oe, band_t ob);
        return '{a_slot: a, b_slot: b, dst_slot: d, cfg_sel: r, coef_hi: hi,
                 use_mul: mul, sub: sub, out_en: oe, out_band: ob};
    endfunction

    // Two-band split: scale, second-order lattice, first-order allpass, sum/difference
    function automatic uop_t split_op(logic [3:0] j, slot_t x, reg_idx_t r2, reg_idx_t r1,
                                      slot_t s1, slot_t s2, slot_t s,
                                      slot_t lo_dst, slot_t hi_dst, logic oe,
                                      band_t lo_band, band_t hi_band);
        uop_t u;
        case (j)
            4'd0:    u = mk(x, SLOT_ZERO, SLOT_XS, r1, K_HI, USE_MUL, OP_ADD, NO_OUT, BAND_LL);
            4'd1:    u = mk(SLOT_XS, s1, SLOT_Y, r2, K_HI, USE_MUL, OP_ADD, NO_OUT, BAND_LL);
            4'd2:    u = mk(SLOT_Y, s2, SLOT_T, r2, K_LO, USE_MUL, OP_SUB, NO_OUT, BAND_LL);
            4'd3:    u = mk(SLOT_XS, SLOT_T, s1, r2, K_LO, USE_MUL, OP_ADD, NO_OUT, BAND_LL);
            4'd4:    u = mk(SLOT_Y, SLOT_XS, s2, r2, K_HI, USE_MUL, OP_SUB, NO_OUT, BAND_LL);
            4'd5:    u = mk(s, SLOT_XS, SLOT_F, r1, K_LO, USE_MUL, OP_SUB, NO_OUT, BAND_LL);
            4'd6:    u = mk(SLOT_F, s, SLOT_Y1, r1, K_LO, USE_MUL, OP_ADD, NO_OUT, BAND_LL);
            4'd7:    u = mk(SLOT_F, SLOT_ZERO, s, r1, K_LO, NO_MUL, OP_ADD, NO_OUT, BAND_LL);
            4'd8:    u = mk(SLOT_Y1, SLOT_Y, lo_dst, r1, K_LO, NO_MUL, OP_ADD, oe, lo_band);
            default: u = mk(SLOT_Y1, SLOT_Y, hi_dst, r1, K_LO, NO_MUL, OP_SUB, oe, hi_band);
        endcase
        return u;
    endfunction

    // Phase-compensating second-order allpass on the low band
    function automatic uop_t comp_op(logic [1:0] j);
        uop_t u;
        case (j)
            2'd0:    u = mk(SLOT_LO, SLOT_CS1, SLOT_CY, REG_HIGH2, K_HI, USE_MUL, OP_ADD,
                            NO_OUT, BAND_LL);
            2'd1:    u = mk(SLOT_CY, SLOT_CS2, SLOT_T, REG_HIGH2, K_LO, USE_MUL, OP_SUB,
                            NO_OUT, BAND_LL);
            2'd2:    u = mk(SLOT_LO, SLOT_T, SLOT_CS1, REG_HIGH2, K_LO, USE_MUL, OP_ADD,
                            NO_OUT, BAND_LL);
            default: u = mk(SLOT_CY, SLOT_LO, SLOT_CS2, REG_HIGH2, K_HI, USE_MUL, OP_SUB,
                            NO_OUT, BAND_LL);
        endcase
        return u;
    endfunction

    // Whole per-channel program: mid split, compensation, low split, high split
    function automatic uop_t uop_at(logic [STEP_W-1:0] step);
        uop_t u;
        if (step < STEP_W'(STEP_COMP))
        begin
            u = split_op(4'(step), SLOT_IN, REG_MID2, REG_MID1, SLOT_MS1, SLOT_MS2, SLOT_MS,
                         SLOT_LO, SLOT_HI, NO_OUT, BAND_LL, BAND_LH);
        end
        else if (step < STEP_W'(STEP_LOW))
        begin
            u = comp_op(2'(step - STEP_W'(STEP_COMP)));
        end
        else if (step < STEP_W'(STEP_HIGH))
        begin
            u = split_op(4'(step - STEP_W'(STEP_LOW)), SLOT_CY, REG_LOW2, REG_LOW1,
                         SLOT_LS1, SLOT_LS2, SLOT_LS, SLOT_OUT, SLOT_OUT, TO_OUT,
                         BAND_LL, BAND_LH);
        end
        else
        begin
            u = split_op(4'(step - STEP_W'(STEP_HIGH)), SLOT_HI, REG_HIGH2, REG_HIGH1,
                         SLOT_HS1, SLOT_HS2, SLOT_HS, SLOT_OUT, SLOT_OUT, TO_OUT,
                         BAND_HL, BAND_HH);
        end
        return u;
    endfunction

endpackage

>>> hw/rtl/allpass_crossover_four_band.sv
// Sequence: each channel runs 25 multiply ops and 9 add ops; a multiply op passes
// ISSUE, MUL_LO, MUL_HI, SCALE and ACC, an add op ISSUE and ACC, then DONE loads the result word.
// Input: a new word is taken only in IDLE, once the previous word is through; the pace is set by the single shared
// 24x25 multiplier and one-port-write scratch memory that run every filter step in turn.
// Reset: asynchronous, active low; clears coefficients and all filter state to zero
// through per-entry valid bits, so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// allpass_crossover_four_band: four-band allpass-complementary crossover
// Splits each channel of a stereo sample pair into four bands using one
// shared multiply-accumulate unit driven by a fixed micro-program.
// ----------------------------------------------------------------------------
module allpass_crossover_four_band #(
    parameter int STATE_WIDTH    = 32,
    parameter int COEF_FRAC_BITS = 22,
    parameter int CHANNELS       = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input word, from bit 0 up: left_in, right_in
    input  logic [apx4_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Output word, from bit 0 up: low_low_left, low_low_right, low_high_left,
    // low_high_right, high_low_left, high_low_right, high_high_left, high_high_right
    output logic [apx4_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [apx4_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [apx4_pkg::CFG_W-1:0]           cfg_data
);

    import apx4_pkg::*;

    localparam int MEM_DEPTH = CHANNELS * SLOT_COUNT;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SUM_W     = FULL_W + 1;

    localparam logic signed [FULL_W-1:0] RND = FULL_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0]  ST_MAX = (SUM_W'(1) <<< (STATE_WIDTH - 1)) - 1;
    localparam logic signed [SUM_W-1:0]  ST_MIN = -ST_MAX - 1;
    localparam logic signed [STATE_WIDTH-1:0] SMP_MAX = STATE_WIDTH'(SAMPLE_MAX);
    localparam logic signed [STATE_WIDTH-1:0] SMP_MIN = STATE_WIDTH'(SAMPLE_MIN);
    localparam logic CH_LAST = 1'(CHANNELS - 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ISSUE  = 7'b0000010,
        ST_MUL_LO = 7'b0000100,
        ST_MUL_HI = 7'b0001000,
        ST_SCALE  = 7'b0010000,
        ST_ACC    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]              step_reg;
    logic                           ch_reg;
    logic signed [SAMPLE_W-1:0]     in_left_reg, in_right_reg;
    logic [CFG_W-1:0]               cfg_reg [REG_COUNT];

    logic signed [STATE_WIDTH-1:0]  mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]           valid_reg;
    logic signed [STATE_WIDTH-1:0]  rd_a_reg, rd_b_reg;
    logic                           a_vld_reg, b_vld_reg;

    logic signed [MUL_W-1:0]        prod_reg, acc_reg;
    logic signed [FULL_W-1:0]       term_reg;
    logic signed [SAMPLE_W-1:0]     stage_reg [BAND_COUNT][MAX_CH];
    logic [OUT_DATA_W-1:0]          out_data_reg;
    logic                           m_tvalid_reg;

    uop_t                           uop;
    logic [ADDR_W-1:0]              addr_a, addr_b, addr_d;
    logic signed [STATE_WIDTH-1:0]  a_val, b_val, res, in_sample;
    logic signed [COEF_W-1:0]       coef;
    logic signed [EXT_W-1:0]        a_ext;
    logic signed [SLICE_W-1:0]      mul_in;
    logic signed [MUL_W-1:0]        prod;
    logic signed [FULL_W-1:0]       full_sum, term;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SAMPLE_W-1:0]     res_out;
    logic [OUT_DATA_W-1:0]          out_word;

    function automatic logic [ADDR_W-1:0] slot_addr(slot_t s, logic c);
        return ADDR_W'(s) + (c ? ADDR_W'(SLOT_COUNT) : ADDR_W'(0));
    endfunction

    // Current micro-op and its scratch addresses
    assign uop    = uop_at(step_reg);
    assign addr_a = slot_addr(uop.a_slot, ch_reg);
    assign addr_b = slot_addr(uop.b_slot, ch_reg);
    assign addr_d = slot_addr(uop.dst_slot, ch_reg);

    // Operand selection; unwritten entries read as zero
    assign in_sample = ch_reg ? STATE_WIDTH'(in_right_reg) : STATE_WIDTH'(in_left_reg);
    assign a_val = (uop.a_slot == SLOT_IN) ? in_sample : (a_vld_reg ? rd_a_reg : '0);
    assign b_val = b_vld_reg ? rd_b_reg : '0;
    assign coef  = uop.coef_hi ? cfg_reg[uop.cfg_sel][CFG_W-1:COEF_W]
                               : cfg_reg[uop.cfg_sel][COEF_W-1:0];

    // Shared multiplier: low 24 bits (unsigned) first, then the signed upper slice
    assign a_ext  = EXT_W'(a_val);
    assign mul_in = (state_reg == ST_MUL_LO) ? $signed({1'b0, a_ext[23:0]})
                                             : $signed(a_ext[EXT_W-1:24]);
    assign prod   = coef * mul_in;

    // Recombine partial products and round half up
    assign full_sum = FULL_W'(acc_reg) + (FULL_W'(prod_reg) <<< 24) + RND;

    // Saturating add or subtract into the state format
    assign term = uop.use_mul ? term_reg : FULL_W'(a_val);
    assign sum  = uop.sub ? (SUM_W'(b_val) - SUM_W'(term)) : (SUM_W'(b_val) + SUM_W'(term));

    always_comb
    begin
        if (sum > ST_MAX)
        begin
            res = STATE_WIDTH'(ST_MAX);
        end
        else if (sum < ST_MIN)
        begin
            res = STATE_WIDTH'(ST_MIN);
        end
        else
        begin
            res = STATE_WIDTH'(sum);
        end
    end

    // Band outputs saturate to the sample format
    always_comb
    begin
        if (res > SMP_MAX)
        begin
            res_out = SAMPLE_W'(SMP_MAX);
        end
        else if (res < SMP_MIN)
        begin
            res_out = SAMPLE_W'(SMP_MIN);
        end
        else
        begin
            res_out = SAMPLE_W'(res);
        end
    end

    // Pack the staged bands; a missing channel reads as zero
    always_comb
    begin
        out_word = '0;
        for (int b = 0; b < BAND_COUNT; b++)
        begin
            for (int c = 0; c < MAX_CH; c++)
            begin
                if (c < CHANNELS)
                begin
                    out_word[(b * MAX_CH + c) * SAMPLE_W +: SAMPLE_W] = stage_reg[b][c];
                end
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = uop.use_mul ? ST_MUL_LO : ST_ACC;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_ACC;
            ST_ACC:
            begin
                if (step_reg == LAST_STEP && ch_reg == CH_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration registers and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            ch_reg       <= 1'b0;
            valid_reg    <= '0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_index < CFG_IDX_W'(REG_COUNT))
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end

            if (state_reg == ST_IDLE && s_tvalid)
            begin
                step_reg <= '0;
                ch_reg   <= 1'b0;
            end

            if (state_reg == ST_ISSUE)
            begin
                a_vld_reg <= valid_reg[addr_a];
                b_vld_reg <= valid_reg[addr_b];
            end

            // Advance through the program, then to the next channel
            if (state_reg == ST_ACC)
            begin
                valid_reg[addr_d] <= 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_reg <= '0;
                    ch_reg   <= (ch_reg == CH_LAST) ? 1'b0 : 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            // Output register: loaded once the previous word has been taken
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers and scratch memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            in_left_reg  <= s_tdata[SAMPLE_W-1:0];
            in_right_reg <= s_tdata[IN_DATA_W-1:SAMPLE_W];
        end

        if (state_reg == ST_ISSUE)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end

        if (state_reg == ST_MUL_LO || state_reg == ST_MUL_HI)
        begin
            prod_reg <= prod;
        end

        if (state_reg == ST_MUL_HI)
        begin
            acc_reg <= prod_reg;
        end

        if (state_reg == ST_SCALE)
        begin
            term_reg <= full_sum >>> COEF_FRAC_BITS;
        end

        if (state_reg == ST_ACC)
        begin
            mem[addr_d] <= res;
            if (uop.out_en)
            begin
                stage_reg[uop.out_band][ch_reg] <= res_out;
            end
        end

        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
        begin
            out_data_reg <= out_word;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTH
    // The channel counter never names a channel that is not built
    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg <= CH_LAST)
        else $error("channel index out of range");

    // Results are never stored into the input or the constant-zero slot
    a_dst_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACC |-> (uop.dst_slot != SLOT_ZERO && uop.dst_slot != SLOT_IN))
        else $error("write to a reserved scratch slot");

    // A multiply op reaches accumulation only through the rounding stage
    a_mul_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && uop.use_mul) |-> $past(state_reg) == ST_SCALE)
        else $error("multiply op skipped the rounding stage");

    // A finished word waits while the output register is still occupied
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready)
        |=> (state_reg == ST_DONE && m_tvalid_reg))
        else $error("output register overwritten before it was taken");
`endif

endmodule
